/* hdl/triangle_face_normal_macros.svh */
// Assertion macros for the triangle face normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

`ifndef SYNTHESIS
`define TFN_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("triangle_face_normal: assertion failed");
`define TFN_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("triangle_face_normal: forbidden condition");
`else
`define TFN_ASSERT(name, prop)
`define TFN_NEVER(name, expr)
`endif

`endif

/* hdl/tfn_pkg.sv */
// Widths, constants and types for the triangle face normal pipeline.
package tfn_pkg;

    localparam int COORD_W   = 16;
    localparam int NUM_COORD = 9;
    localparam int IN_DATA_W = COORD_W * NUM_COORD;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int SUM_W     = 2 * MAG_W;
    localparam int ROOT_W    = 35;
    localparam int Q_W       = 15;
    localparam int N_W       = 16;
    localparam int OUT_DATA_W = 3 * N_W;
    localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } side_t;

endpackage

/* hdl/triangle_face_normal.sv */
// Throughput: one triangle per cycle while the output is taken or a stage is
// empty; the 35 square-root digit stages and 15 divider bit stages are fully
// pipelined, one stage per register. Backpressure collapses bubbles: a stage
// advances when it or any later stage is empty or the output is taken. rst_n
// (async, active low) clears only the valid bits; the pipeline is empty right after reset.
module triangle_face_normal (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz (16 bits each, lowest first)
    input  logic [tfn_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // nx, ny, nz (16 bits each, lowest first)
    output logic [tfn_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // degenerate
    output logic                              m_axis_tuser
);
    import tfn_pkg::*;
    `include "triangle_face_normal_macros.svh"

    localparam int SQ0  = 5;
    localparam int DV0  = SQ0 + ROOT_W;
    localparam int OUTS = DV0 + Q_W;
    localparam int NST  = OUTS + 1;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            en[k] = m_axis_tready || (|((~vld_reg) >> k));
        end
        for (int k = 0; k < NST; k++)
        begin
            if (!en[k])
                vld_next[k] = vld_reg[k];
            else if (k == 0)
                vld_next[k] = s_axis_tvalid;
            else
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NST-1];

    // stage 0: edges B-A and C-A
    logic signed [COORD_W-1:0] crd [NUM_COORD];
    logic signed [EDGE_W-1:0]  e_reg [6];

    always_comb
    begin
        for (int i = 0; i < NUM_COORD; i++)
        begin
            crd[i] = s_axis_tdata[i*COORD_W +: COORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i]   <= EDGE_W'(crd[3+i]) - EDGE_W'(crd[i]);
                e_reg[3+i] <= EDGE_W'(crd[6+i]) - EDGE_W'(crd[i]);
            end
        end
    end

    // stage 1: six partial products of the cross product
    logic signed [PROD_W-1:0] p_reg [6];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg[0] <= PROD_W'(e_reg[1]) * PROD_W'(e_reg[5]);
            p_reg[1] <= PROD_W'(e_reg[2]) * PROD_W'(e_reg[4]);
            p_reg[2] <= PROD_W'(e_reg[2]) * PROD_W'(e_reg[3]);
            p_reg[3] <= PROD_W'(e_reg[0]) * PROD_W'(e_reg[5]);
            p_reg[4] <= PROD_W'(e_reg[0]) * PROD_W'(e_reg[4]);
            p_reg[5] <= PROD_W'(e_reg[1]) * PROD_W'(e_reg[3]);
        end
    end

    // stage 2: cross product, split into sign and magnitude
    logic signed [CROSS_W-1:0] cr [3];
    logic [CROSS_W-1:0]        cr_abs [3];
    side_t                     side2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cr[i]     = CROSS_W'(p_reg[2*i]) - CROSS_W'(p_reg[2*i+1]);
            cr_abs[i] = cr[i][CROSS_W-1] ? (CROSS_W'(0) - cr[i]) : cr[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                side2_reg.neg[i] <= cr[i][CROSS_W-1];
                side2_reg.mag[i] <= cr_abs[i][MAG_W-1:0];
            end
        end
    end

    // stage 3: squares
    logic [SUM_W-1:0] sq_reg [3];
    side_t            side3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= side2_reg.mag[i] * side2_reg.mag[i];
            end
            side3_reg <= side2_reg;
        end
    end

    // stage 4: squared length
    logic [SUM_W-1:0] sum_reg;
    side_t            side4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            side4_reg <= side3_reg;
        end
    end

    // square root, one result bit per stage, most significant first
    logic [SUM_W-1:0]  rem_w  [ROOT_W+1];
    logic [ROOT_W-1:0] root_w [ROOT_W+1];
    side_t             side_w [ROOT_W+1];

    assign rem_w[0]  = sum_reg;
    assign root_w[0] = '0;
    assign side_w[0] = side4_reg;

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        tfn_sqrt_step #(
            .BIT (ROOT_W - 1 - j)
        ) u_step (
            .clk      (clk),
            .en       (en[SQ0+j]),
            .rem_in   (rem_w[j]),
            .root_in  (root_w[j]),
            .rem_reg  (rem_w[j+1]),
            .root_reg (root_w[j+1])
        );

        side_t side_reg;
        always_ff @(posedge clk)
        begin
            if (en[SQ0+j])
                side_reg <= side_w[j];
        end
        assign side_w[j+1] = side_reg;
    end

    // divide each magnitude scaled by 2^14 by the length
    logic [ROOT_W-1:0] len_w [Q_W+1];
    logic [2:0]        neg_w [Q_W+1];
    logic [ROOT_W-1:0] drem_w [3][Q_W+1];
    logic [Q_W-1:0]    q_w    [3][Q_W+1];

    assign len_w[0] = root_w[ROOT_W];
    assign neg_w[0] = side_w[ROOT_W].neg;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        assign drem_w[i][0] = ROOT_W'(side_w[ROOT_W].mag[i]);
        assign q_w[i][0]    = '0;
        for (genvar j = 0; j < Q_W; j++)
        begin : g_bit
            tfn_div_step #(
                .FIRST (j == 0)
            ) u_step (
                .clk     (clk),
                .en      (en[DV0+j]),
                .rem_in  (drem_w[i][j]),
                .q_in    (q_w[i][j]),
                .len     (len_w[j]),
                .rem_reg (drem_w[i][j+1]),
                .q_reg   (q_w[i][j+1])
            );
        end
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div_side
        logic [ROOT_W-1:0] len_reg;
        logic [2:0]        neg_reg;
        always_ff @(posedge clk)
        begin
            if (en[DV0+j])
            begin
                len_reg <= len_w[j];
                neg_reg <= neg_w[j];
            end
        end
        assign len_w[j+1] = len_reg;
        assign neg_w[j+1] = neg_reg;
    end

    // output stage: clamp, restore sign, flag a zero-length normal
    logic [N_W-1:0] n_reg [3];
    logic           deg_reg;
    logic           degen;
    logic [Q_W-1:0] qc [3];
    logic [N_W-1:0] nv [3];

    always_comb
    begin
        degen = len_w[Q_W] == '0;
        for (int i = 0; i < 3; i++)
        begin
            qc[i] = (q_w[i][Q_W] > ONE_Q14) ? ONE_Q14 : q_w[i][Q_W];
            nv[i] = neg_w[Q_W][i] ? (N_W'(0) - N_W'(qc[i])) : N_W'(qc[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUTS])
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= degen ? '0 : nv[i];
            end
            deg_reg <= degen;
        end
    end

    assign m_axis_tdata = {n_reg[2], n_reg[1], n_reg[0]};
    assign m_axis_tuser = deg_reg;

    `TFN_ASSERT(a_ready_when_out_empty, !vld_reg[NST-1] |-> s_axis_tready)
    `TFN_ASSERT(a_degen_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    `TFN_NEVER(a_nx_range, m_axis_tvalid && ($signed(n_reg[0]) > 16384 || $signed(n_reg[0]) < -16384))

endmodule

/* hdl/tfn_sqrt_step.sv */
// One digit of the pipelined integer square root: trial subtract and register.
module tfn_sqrt_step #(
    parameter int BIT = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [tfn_pkg::SUM_W-1:0]  rem_in,
    input  logic [tfn_pkg::ROOT_W-1:0] root_in,
    output logic [tfn_pkg::SUM_W-1:0]  rem_reg,
    output logic [tfn_pkg::ROOT_W-1:0] root_reg
);
    import tfn_pkg::*;

    localparam int TW = SUM_W + 3;

    logic [TW-1:0]     trial;
    logic              take;
    logic [SUM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // root only has bits above BIT here, so the two terms never overlap
    always_comb
    begin
        trial     = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        take      = TW'(rem_in) >= trial;
        rem_next  = take ? (rem_in - trial[SUM_W-1:0]) : rem_in;
        root_next = take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

/* hdl/tfn_div_step.sv */
// One quotient bit of the restoring divider for one normal component.
module tfn_div_step #(
    parameter bit FIRST = 1'b0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [tfn_pkg::ROOT_W-1:0] rem_in,
    input  logic [tfn_pkg::Q_W-1:0]    q_in,
    input  logic [tfn_pkg::ROOT_W-1:0] len,
    output logic [tfn_pkg::ROOT_W-1:0] rem_reg,
    output logic [tfn_pkg::Q_W-1:0]    q_reg
);
    import tfn_pkg::*;

    logic [ROOT_W:0]   r_sh;
    logic [ROOT_W:0]   r_sub;
    logic              ge;
    logic [ROOT_W-1:0] rem_next;

    // first step takes the integer bit, the rest shift in one bit each
    always_comb
    begin
        r_sh     = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
        r_sub    = r_sh - {1'b0, len};
        ge       = r_sh >= {1'b0, len};
        rem_next = ge ? r_sub[ROOT_W-1:0] : r_sh[ROOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_in[Q_W-2:0], ge};
        end
    end

endmodule
